// ----- design/hgcd_pkg.sv -----
// Package with constants, the arctangent table and the Q30 multiply for the haversine unit.
`default_nettype none
package hgcd_pkg;

  localparam int ANGLE_BITS    = 32;
  localparam int CORDIC_STAGES = 24;
  localparam int XY_W          = 34;
  localparam int Z_W           = 34;
  localparam int ROOT_STEPS    = 31;
  localparam int REM_W         = 62;
  localparam int DIST_W        = 23;
  localparam int DIST_SHIFT    = 38;

  localparam logic [31:0] ANGLE_MASK = 32'hFFFF_FFFF << (32 - ANGLE_BITS);
  localparam logic signed [XY_W-1:0] CORDIC_GAIN = XY_W'(652032874);
  localparam logic [30:0] Q30_ONE = 31'h4000_0000;
  localparam logic [30:0] DIST_SCALE = 31'd1311708728;

  localparam logic [31:0] ARC_TABLE [32] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
    32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
  };

  function automatic logic signed [XY_W-1:0] q30_mul(input logic signed [XY_W-1:0] a,
                                                     input logic signed [XY_W-1:0] b);
    logic signed [2*XY_W-1:0] p;
    p = a * b;
    p = p + (2*XY_W)'(64'sd536870912);
    return XY_W'(p >>> 30);
  endfunction

endpackage
`default_nettype wire

// ----- design/haversine_great_circle_distance_unit.sv -----
// Top level of the pipelined haversine great-circle distance unit.
//
// Usage: drive the four angle ports and raise start_i for one cycle to hand
// over an item; an item is taken at every rising edge where start_i is high
// and busy_o is low. busy_o is always low, so a new item may enter in every
// cycle and the unit sustains one item per clock.
// Each result appears on distance_km_o for exactly one cycle, marked by
// valid_o. The fully unrolled pipeline holds the input register, 24
// rotation CORDIC stages, four stages of products and clamping, 31
// square-root digit stages, 24 vectoring CORDIC stages and two stages
// for the final scaling. Results leave in the order the items came in.
// The receiver cannot hold results off, so the pipeline never stalls.
// Reset clears only the valid bits; data registers carry no reset.
`default_nettype none
module haversine_great_circle_distance_unit
  import hgcd_pkg::*;
(
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     start_i,
  output logic                          busy_o,
  input  wire logic signed [31:0]       first_latitude_i,
  input  wire logic signed [31:0]       first_longitude_i,
  input  wire logic signed [31:0]       second_latitude_i,
  input  wire logic signed [31:0]       second_longitude_i,
  output logic                          valid_o,
  output logic [DIST_W-1:0]             distance_km_o
);

  localparam int LATENCY = 2 * CORDIC_STAGES + ROOT_STEPS + 7;

  logic [LATENCY-1:0] vld_q;

  logic signed [XY_W-1:0] rx_q [4][CORDIC_STAGES+1];
  logic signed [XY_W-1:0] ry_q [4][CORDIC_STAGES+1];
  logic [31:0]            rz_q [4][CORDIC_STAGES+1];
  logic [3:0]             flip_q [CORDIC_STAGES+1];

  logic [31:0] lat1, lon1, lat2, lon2, dlat, dlon;
  logic [31:0] ang [4];

  logic signed [XY_W-1:0] c1_q, c2_q, sd_q, sl_q;
  logic signed [XY_W-1:0] pcc_q, pll_q, pdd_q;
  logic signed [XY_W-1:0] t_q, pdd2_q;
  logic signed [XY_W:0]   a_sum;
  logic [30:0]            a_q, b_q;

  logic [REM_W-1:0] rem_q  [2][ROOT_STEPS+1];
  logic [30:0]      root_q [2][ROOT_STEPS+1];

  logic signed [XY_W-1:0] vx_q [CORDIC_STAGES+1];
  logic signed [XY_W-1:0] vy_q [CORDIC_STAGES+1];
  logic signed [Z_W-1:0]  vz_q [CORDIC_STAGES+1];

  logic [30:0] zc;
  logic [61:0] prod_q;
  logic [61:0] prod_rnd;

  assign busy_o = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[LATENCY-2:0], start_i};
    end
  end

  always_comb begin
    lat1 = first_latitude_i & ANGLE_MASK;
    lon1 = first_longitude_i & ANGLE_MASK;
    lat2 = second_latitude_i & ANGLE_MASK;
    lon2 = second_longitude_i & ANGLE_MASK;
    dlat = lat2 - lat1;
    dlon = lon2 - lon1;
    ang[0] = lat1;
    ang[1] = lat2;
    ang[2] = {dlat[31], dlat[31:1]};
    ang[3] = {dlon[31], dlon[31:1]};
  end

  for (genvar u = 0; u < 4; u++) begin : g_rot
    always_ff @(posedge clk_i) begin
      flip_q[0][u] <= ang[u][31] ^ ang[u][30];
      rx_q[u][0]   <= CORDIC_GAIN;
      ry_q[u][0]   <= '0;
      rz_q[u][0]   <= {ang[u][30], ang[u][30:0]};
    end
    for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
      always_ff @(posedge clk_i) begin
        if (!rz_q[u][i][31]) begin
          rx_q[u][i+1] <= rx_q[u][i] - (ry_q[u][i] >>> i);
          ry_q[u][i+1] <= ry_q[u][i] + (rx_q[u][i] >>> i);
          rz_q[u][i+1] <= rz_q[u][i] - ARC_TABLE[i];
        end else begin
          rx_q[u][i+1] <= rx_q[u][i] + (ry_q[u][i] >>> i);
          ry_q[u][i+1] <= ry_q[u][i] - (rx_q[u][i] >>> i);
          rz_q[u][i+1] <= rz_q[u][i] + ARC_TABLE[i];
        end
      end
    end
  end

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_flip
    always_ff @(posedge clk_i) begin
      flip_q[i+1] <= flip_q[i];
    end
  end

  always_ff @(posedge clk_i) begin
    c1_q <= flip_q[CORDIC_STAGES][0] ? -rx_q[0][CORDIC_STAGES] : rx_q[0][CORDIC_STAGES];
    c2_q <= flip_q[CORDIC_STAGES][1] ? -rx_q[1][CORDIC_STAGES] : rx_q[1][CORDIC_STAGES];
    sd_q <= flip_q[CORDIC_STAGES][2] ? -ry_q[2][CORDIC_STAGES] : ry_q[2][CORDIC_STAGES];
    sl_q <= flip_q[CORDIC_STAGES][3] ? -ry_q[3][CORDIC_STAGES] : ry_q[3][CORDIC_STAGES];
    pcc_q  <= q30_mul(c1_q, c2_q);
    pll_q  <= q30_mul(sl_q, sl_q);
    pdd_q  <= q30_mul(sd_q, sd_q);
    t_q    <= q30_mul(pcc_q, pll_q);
    pdd2_q <= pdd_q;
  end

  assign a_sum = {pdd2_q[XY_W-1], pdd2_q} + {t_q[XY_W-1], t_q};

  always_ff @(posedge clk_i) begin
    if (a_sum[XY_W]) begin
      a_q <= '0;
      b_q <= Q30_ONE;
    end else if (a_sum > (XY_W+1)'(Q30_ONE)) begin
      a_q <= Q30_ONE;
      b_q <= '0;
    end else begin
      a_q <= a_sum[30:0];
      b_q <= Q30_ONE - a_sum[30:0];
    end
  end

  assign rem_q[0][0]  = {1'b0, a_q, 30'd0};
  assign rem_q[1][0]  = {1'b0, b_q, 30'd0};
  assign root_q[0][0] = '0;
  assign root_q[1][0] = '0;

  for (genvar r = 0; r < 2; r++) begin : g_sqrt
    for (genvar j = 0; j < ROOT_STEPS; j++) begin : g_digit
      localparam int K = ROOT_STEPS - 1 - j;
      logic [REM_W-1:0] trial;
      assign trial = (REM_W'(root_q[r][j]) << (K + 1)) | (REM_W'(1) << (2 * K));
      always_ff @(posedge clk_i) begin
        if (rem_q[r][j] >= trial) begin
          rem_q[r][j+1]  <= rem_q[r][j] - trial;
          root_q[r][j+1] <= root_q[r][j] | (31'd1 << K);
        end else begin
          rem_q[r][j+1]  <= rem_q[r][j];
          root_q[r][j+1] <= root_q[r][j];
        end
      end
    end
  end

  assign vx_q[0] = XY_W'(root_q[1][ROOT_STEPS]);
  assign vy_q[0] = XY_W'(root_q[0][ROOT_STEPS]);
  assign vz_q[0] = '0;

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_vec
    always_ff @(posedge clk_i) begin
      if (!vy_q[i][XY_W-1]) begin
        vx_q[i+1] <= vx_q[i] + (vy_q[i] >>> i);
        vy_q[i+1] <= vy_q[i] - (vx_q[i] >>> i);
        vz_q[i+1] <= vz_q[i] + Z_W'(ARC_TABLE[i]);
      end else begin
        vx_q[i+1] <= vx_q[i] - (vy_q[i] >>> i);
        vy_q[i+1] <= vy_q[i] + (vx_q[i] >>> i);
        vz_q[i+1] <= vz_q[i] - Z_W'(ARC_TABLE[i]);
      end
    end
  end

  always_comb begin
    if (vz_q[CORDIC_STAGES][Z_W-1]) begin
      zc = '0;
    end else if (vz_q[CORDIC_STAGES] > Z_W'(Q30_ONE)) begin
      zc = Q30_ONE;
    end else begin
      zc = vz_q[CORDIC_STAGES][30:0];
    end
  end

  assign prod_rnd = prod_q + (62'd1 << (DIST_SHIFT - 1));

  always_ff @(posedge clk_i) begin
    prod_q        <= 62'(zc) * 62'(DIST_SCALE);
    distance_km_o <= prod_rnd[DIST_SHIFT +: DIST_W];
  end

  assign valid_o = vld_q[LATENCY-1];

endmodule
`default_nettype wire
